// ===== rtl/core/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants for the lattice topological charge block
// Payload structs, controller/datapath command and status, arctangent table.
// ----------------------------------------------------------------------------
package ltc_pkg;

  // One site spin as it is kept in the row store
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } ltc_spin_t;

  // Input transaction payload
  typedef struct packed {
    logic signed [15:0] spin_x;
    logic signed [15:0] spin_y;
    logic signed [15:0] spin_z;
    logic               end_of_frame;
  } ltc_in_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [31:0] charge;
    logic               polarity;
  } ltc_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;      // latch input site, fold column wrap
    logic       rd_en;       // row store read
    logic       rd_col;      // 0: column-1, 1: column
    logic       cap_s1;      // capture lower-left corner
    logic       cap_s2;      // capture lower-right corner
    logic       tri_sel;     // 0: (s1,s2,cur), 1: (s1,cur,left)
    logic       st1;         // cross terms and dot products
    logic       st2;         // triple product terms, denominator
    logic       st3;         // numerator sum
    logic       cordic_load; // quadrant pre-rotation
    logic       cordic_step; // one vectoring iteration
    logic [4:0] iter;        // iteration index
    logic       acc;         // add triangle angle to sum
    logic       wr_en;       // row store write
    logic       wr_col;      // 0: left site at column-1, 1: current at column
    logic       update;      // advance column, left site, peak
    logic       chg_mul;     // charge partial products
    logic       load_out;    // load result register, clear frame state
  } ltc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_plaq; // a full plaquette ends at this site
    logic col_nz;    // column is not zero
    logic row_end;   // last site of a row
    logic eof;       // site closes the frame
  } ltc_stat_t;

  localparam int                 ROW_LEN_W   = 9;
  localparam logic [8:0]         ROW_LEN_RST = 9'd146;
  localparam int                 CORDIC_W    = 52;
  localparam int                 ANGLE_W     = 33;
  localparam int                 SUM_W       = 40;
  localparam int                 CHG_LO_W    = 20;
  localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic [20:0]        INV_4PI_Q24 = 21'd1335088;

  // atan(2^-i) in radians, 30 fraction bits
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/lattice_topological_charge.sv =====
// ----------------------------------------------------------------------------
// lattice_topological_charge: lattice skyrmion number from a raster spin stream
// Solid-angle sum over plaquette triangles with CORDIC atan2, charge at frame end.
// ----------------------------------------------------------------------------
// Flow: one site at a time; a new site is taken only once the last one is done.
//   A site with a full plaquette runs the shared CORDIC unit twice, once per
//   triangle. At frame end the charge is scaled, then loaded into the result
//   register, which waits while a previous result has not been taken.
// Reset: synchronous rst_n clears control state; row store is not cleared.
module lattice_topological_charge import ltc_pkg::*; #(
  parameter int ROW_MAX          = 256,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  ltc_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ltc_out_t   out_data
);

  ltc_cmd_t  cmd;
  ltc_stat_t stat;

  // Sequencer
  ltc_ctrl #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and state
  ltc_dp #(
    .ROW_MAX (ROW_MAX)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/ltc_ram.sv =====
// ----------------------------------------------------------------------------
// ltc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ltc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ltc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltc_ctrl: sequencer for the lattice topological charge block
// Steps each site through row store reads and two triangle evaluations where a
// full plaquette ends, row store writes and, at frame end, the charge scaling and result load.
// ----------------------------------------------------------------------------
module ltc_ctrl import ltc_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ltc_stat_t stat,
  output ltc_cmd_t  cmd
);

  localparam int IT_W = $clog2(ANGLE_ITERATIONS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_ST1, S_ST2, S_ST3, S_LOAD,
    S_ITER, S_ACC, S_WR1, S_WR2, S_UPD, S_CHG, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic            tri_r, tri_nxt;
  logic [IT_W-1:0] iter_r, iter_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    tri_nxt       = tri_r;
    iter_nxt      = iter_r;
    cmd           = '0;
    cmd.tri_sel   = tri_r;
    cmd.iter      = 5'(iter_r);
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_RD1;
      end
      S_RD1: begin
        if (stat.need_plaq) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_RD2;
        end else begin
          state_nxt = S_WR1;
        end
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_col = 1'b1;
        cmd.cap_s1 = 1'b1;
        state_nxt  = S_RD3;
      end
      S_RD3: begin
        cmd.cap_s2 = 1'b1;
        tri_nxt    = 1'b0;
        state_nxt  = S_ST1;
      end
      S_ST1: begin
        cmd.st1   = 1'b1;
        state_nxt = S_ST2;
      end
      S_ST2: begin
        cmd.st2   = 1'b1;
        state_nxt = S_ST3;
      end
      S_ST3: begin
        cmd.st3   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.cordic_load = 1'b1;
        iter_nxt        = '0;
        state_nxt       = S_ITER;
      end
      S_ITER: begin
        cmd.cordic_step = 1'b1;
        iter_nxt        = iter_r + 1'b1;
        if (iter_r == IT_W'(ANGLE_ITERATIONS - 1)) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (!tri_r) begin
          tri_nxt   = 1'b1;
          state_nxt = S_ST1;
        end else begin
          state_nxt = S_WR1;
        end
      end
      S_WR1: begin
        cmd.wr_en = stat.col_nz;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.wr_en  = stat.row_end;
        cmd.wr_col = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = stat.eof ? S_CHG : S_IDLE;
      end
      S_CHG: begin
        cmd.chg_mul = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tri_r       <= 1'b0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tri_r       <= tri_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // An accepted transaction always starts the read phase
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_RD1))
    else $error("accept did not start site sequence");

  // Angle accumulation only after the last iteration
  a_acc_after_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> ($past(state_r) == S_ITER))
    else $error("accumulate without finished iterations");

endmodule

// ===== rtl/core/ltc_dp.sv =====
// ----------------------------------------------------------------------------
// ltc_dp: datapath for the lattice topological charge block
// Row store, site registers, triple product and dot sums, CORDIC atan2,
// saturating angle sum, peak z tracking and charge scaling.
// ----------------------------------------------------------------------------
module ltc_dp import ltc_pkg::*; #(
  parameter int ROW_MAX = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [8:0]      cfg_data,
  input  ltc_in_t         in_data,
  input  ltc_cmd_t        cmd,
  output ltc_stat_t       stat,
  output ltc_out_t        out_data
);

  localparam int COL_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int LEN_W = $clog2(ROW_MAX + 1);
  localparam int CMP_W = LEN_W + 1;

  // Control state
  logic [ROW_LEN_W-1:0]      row_length_r;
  logic [COL_W-1:0]          col_r;
  logic                      first_row_r;
  logic signed [SUM_W-1:0]   angle_sum_r;
  logic signed [15:0]        peak_r;
  ltc_spin_t                 left_r;

  // Payload registers
  ltc_spin_t                 cur_r, s1_r, s2_r;
  logic                      eof_r;
  logic signed [32:0]        crx_r, cry_r, crz_r, dab_r, dac_r, dbc_r;
  logic signed [48:0]        n0_r, n1_r, n2_r, num_r;
  logic signed [34:0]        den_r;
  logic signed [CORDIC_W-1:0] cx_r, cy_r;
  logic signed [ANGLE_W-1:0] cz_r;
  logic                      zero_r;
  logic [40:0]               chg_lo_r;
  logic signed [41:0]        chg_hi_r;
  ltc_out_t                  out_r;

  // Clamped row length and column wrap
  logic [LEN_W-1:0] len;
  logic             wrap;
  always_comb begin
    if (row_length_r < 9'd2) len = LEN_W'(2);
    else if (32'(row_length_r) > ROW_MAX) len = LEN_W'(ROW_MAX);
    else len = LEN_W'(row_length_r);
  end
  assign wrap = (CMP_W'(col_r) >= CMP_W'(len));

  assign stat.need_plaq = (col_r != '0) && !first_row_r;
  assign stat.col_nz    = (col_r != '0);
  assign stat.row_end   = ((CMP_W'(col_r) + CMP_W'(1)) >= CMP_W'(len));
  assign stat.eof       = eof_r;

  // Row store
  logic [COL_W-1:0] col_m1;
  logic [$bits(ltc_spin_t)-1:0] ram_rdata;
  assign col_m1 = col_r - 1'b1;

  ltc_ram #(
    .WIDTH ($bits(ltc_spin_t)),
    .DEPTH (ROW_MAX)
  ) u_row_store (
    .clk     (clk),
    .we      (cmd.wr_en),
    .waddr   (cmd.wr_col ? col_r : col_m1),
    .wdata   (cmd.wr_col ? cur_r : left_r),
    .re      (cmd.rd_en),
    .raddr   (cmd.rd_col ? col_r : col_m1),
    .rdata_r (ram_rdata)
  );

  // Triangle corners
  ltc_spin_t ta, tb, tc;
  assign ta = s1_r;
  assign tb = cmd.tri_sel ? cur_r  : s2_r;
  assign tc = cmd.tri_sel ? left_r : cur_r;

  // Stage 1: cross product of b and c, pairwise dots
  logic signed [32:0] crx, cry, crz, dab, dac, dbc;
  assign crx = tb.y * tc.z - tb.z * tc.y;
  assign cry = tb.z * tc.x - tb.x * tc.z;
  assign crz = tb.x * tc.y - tb.y * tc.x;
  assign dab = ta.x * tb.x + ta.y * tb.y + ta.z * tb.z;
  assign dac = ta.x * tc.x + ta.y * tc.y + ta.z * tc.z;
  assign dbc = tb.x * tc.x + tb.y * tc.y + tb.z * tc.z;

  // CORDIC pre-rotation and step
  logic signed [48:0]         den_sh;
  logic signed [CORDIC_W-1:0] num_e, den_e, dx, dy;
  logic signed [ANGLE_W-1:0]  at;
  assign den_sh = $signed({den_r, 14'b0});
  assign num_e  = CORDIC_W'(num_r);
  assign den_e  = CORDIC_W'(den_sh);
  assign dx     = cy_r >>> cmd.iter;
  assign dy     = cx_r >>> cmd.iter;
  assign at     = $signed({1'b0, atan_q30(cmd.iter)});

  // Triangle angle rounded to 25 fraction bits, saturating add
  logic signed [ANGLE_W-1:0] z_fin, tri_ang;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [SUM_W-1:0]   sum_sat;
  assign z_fin   = zero_r ? '0 : cz_r;
  assign tri_ang = (z_fin + 33'sd16) >>> 5;
  assign sum_ext = (SUM_W+1)'(angle_sum_r) + (SUM_W+1)'(tri_ang);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sum_sat = sum_ext[SUM_W-1:0];
  end

  // Peak z magnitude compare
  logic [16:0] az, ap;
  assign az = cur_r.z[15] ? 17'(-18'(cur_r.z)) : 17'(cur_r.z);
  assign ap = peak_r[15]  ? 17'(-18'(peak_r))  : 17'(peak_r);

  // Charge: sum * 2^24/(4 pi) / 2^32, rounded; |sum| <= 2^39 keeps it in 32 bits
  logic signed [63:0] chg_sum;
  assign chg_sum = (64'(chg_hi_r) <<< CHG_LO_W) + 64'($signed({1'b0, chg_lo_r}))
                 + 64'sd2147483648;

  // Control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LEN_RST;
      col_r        <= '0;
      first_row_r  <= 1'b1;
      angle_sum_r  <= '0;
      peak_r       <= '0;
      left_r       <= '0;
    end else begin
      if (cfg_we) row_length_r <= cfg_data;
      if (cmd.accept && wrap) begin
        col_r       <= '0;
        first_row_r <= 1'b0;
      end
      if (cmd.acc) angle_sum_r <= sum_sat;
      if (cmd.update) begin
        left_r <= cur_r;
        if (az > ap) peak_r <= cur_r.z;
        if (stat.row_end) begin
          col_r       <= '0;
          first_row_r <= 1'b0;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (cmd.load_out) begin
        col_r       <= '0;
        first_row_r <= 1'b1;
        angle_sum_r <= '0;
        peak_r      <= '0;
        left_r      <= '0;
      end
    end
  end

  // Arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r <= '{x: in_data.spin_x, y: in_data.spin_y, z: in_data.spin_z};
      eof_r <= in_data.end_of_frame;
    end
    if (cmd.cap_s1) s1_r <= ram_rdata;
    if (cmd.cap_s2) s2_r <= ram_rdata;
    if (cmd.st1) begin
      crx_r <= crx;
      cry_r <= cry;
      crz_r <= crz;
      dab_r <= dab;
      dac_r <= dac;
      dbc_r <= dbc;
    end
    if (cmd.st2) begin
      n0_r  <= ta.x * crx_r;
      n1_r  <= ta.y * cry_r;
      n2_r  <= ta.z * crz_r;
      den_r <= 35'sd268435456 + dab_r + dac_r + dbc_r;
    end
    if (cmd.st3) num_r <= n0_r + n1_r + n2_r;
    if (cmd.cordic_load) begin
      zero_r <= (num_r == '0) && (den_r == '0);
      if (!den_r[34]) begin
        cx_r <= den_e;
        cy_r <= num_e;
        cz_r <= '0;
      end else if (!num_r[48]) begin
        cx_r <= num_e;
        cy_r <= -den_e;
        cz_r <= HALF_PI_Q30;
      end else begin
        cx_r <= -num_e;
        cy_r <= den_e;
        cz_r <= -HALF_PI_Q30;
      end
    end
    if (cmd.cordic_step) begin
      if (!cy_r[CORDIC_W-1]) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - at;
      end
    end
    if (cmd.chg_mul) begin
      // low slice unsigned, high slice carries the sign
      chg_lo_r <= angle_sum_r[CHG_LO_W-1:0] * INV_4PI_Q24;
      chg_hi_r <= $signed(angle_sum_r[SUM_W-1:CHG_LO_W]) * $signed({1'b0, INV_4PI_Q24});
    end
    if (cmd.load_out) begin
      out_r.charge   <= chg_sum[63:32];
      out_r.polarity <= (peak_r > 16'sd0);
    end
  end

  assign out_data = out_r;

endmodule
